// ===== hw/rtl/wsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types, codes and helpers of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfd_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned OpW     = 4;
	localparam int unsigned ActW    = 3;
	localparam int unsigned Len7W   = 7;
	localparam int unsigned LenW    = 64;
	localparam int unsigned KeyW    = 32;
	localparam int unsigned KeyIdxW = 2;
	localparam int unsigned ExtCntW = 4;

	localparam logic [Len7W-1:0] Len16Code = 7'd126;
	localparam logic [Len7W-1:0] Len64Code = 7'd127;
	localparam logic [ExtCntW-1:0] Ext16Bytes = 4'd2;
	localparam logic [ExtCntW-1:0] Ext64Bytes = 4'd8;

	typedef enum logic [OpW-1:0] {
		OP_CONT   = 4'h0,
		OP_TEXT   = 4'h1,
		OP_BINARY = 4'h2,
		OP_CLOSE  = 4'h8,
		OP_PING   = 4'h9,
		OP_PONG   = 4'hA
	} opcode_t;

	typedef enum logic [ActW-1:0] {
		ACT_DELIVER = 3'd0,
		ACT_ECHO    = 3'd1,
		ACT_CLOSE   = 3'd2,
		ACT_PONG    = 3'd3,
		ACT_IGNORE  = 3'd4
	} action_t;

	typedef enum logic [4:0] {
		PH_HDR0 = 5'b00001,
		PH_HDR1 = 5'b00010,
		PH_EXT  = 5'b00100,
		PH_KEY  = 5'b01000,
		PH_DATA = 5'b10000
	} phase_t;

	function automatic action_t action_of(input logic [OpW-1:0] op);
		action_t a;
		case (op)
			OP_TEXT, OP_BINARY: a = ACT_DELIVER;
			OP_PING:            a = ACT_ECHO;
			OP_CLOSE:           a = ACT_CLOSE;
			OP_PONG:            a = ACT_PONG;
			default:            a = ACT_IGNORE;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wsfd_if.sv =====
// ----------------------------------------------------------------------------
// wsfd channel interfaces
// Valid/ready channels for received bytes and for deframed results.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsfd_in_if;
	logic                       valid;
	logic                       ready;
	logic [wsfd_pkg::ByteW-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsfd_out_if;
	logic                       valid;
	logic                       ready;
	logic [wsfd_pkg::ActW-1:0]  action;
	logic [wsfd_pkg::OpW-1:0]   frame_opcode;
	logic                       has_data;
	logic [wsfd_pkg::ByteW-1:0] payload_byte;
	logic                       frame_end;

	modport source (output valid, output action, output frame_opcode, output has_data,
		output payload_byte, output frame_end, input ready);
	modport sink (input valid, input action, input frame_opcode, input has_data,
		input payload_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket frame parser: header decode, payload unmasking and
// per-frame action tagging, one stream byte per transfer.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  in_ch    | in  | rx_byte
//  out_ch   | out | action, frame_opcode, has_data, payload_byte, frame_end
//
//  one byte per cycle while the output register is empty or drained; a result is
//  in the output register the cycle after its byte is taken (single output stage)
//  input is taken whenever the output register is empty or being drained
//  reset clears the parser to expect a first header byte, connection open
//  after a close frame ends, bytes are still taken and dropped
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer (
	input  wire             clk,
	input  wire             arst_n,
	wsfd_in_if.sink         in_ch,
	wsfd_out_if.source      out_ch
);

	wsfd_pkg::phase_t                phase_q, phase_d;
	logic [wsfd_pkg::OpW-1:0]        opcode_q, opcode_d;
	logic                            masked_q, masked_d;
	logic [wsfd_pkg::ExtCntW-1:0]    ext_cnt_q, ext_cnt_d;
	logic [wsfd_pkg::LenW-1:0]       rem_q, rem_d;
	logic [wsfd_pkg::KeyW-1:0]       key_q, key_d;
	logic [wsfd_pkg::KeyIdxW-1:0]    kidx_q, kidx_d;
	logic                            closed_q, closed_d;

	logic                            out_vld_q;
	logic [wsfd_pkg::ActW-1:0]       out_act_q;
	logic [wsfd_pkg::OpW-1:0]        out_op_q;
	logic                            out_data_q;
	logic [wsfd_pkg::ByteW-1:0]      out_byte_q;
	logic                            out_end_q;

	logic                            in_acc;
	logic                            emit;
	logic                            emit_data;
	logic                            emit_end;
	logic [wsfd_pkg::ByteW-1:0]      emit_byte;
	logic [wsfd_pkg::ByteW-1:0]      b;
	logic [wsfd_pkg::Len7W-1:0]      len7;
	logic [wsfd_pkg::ByteW-1:0]      kb;
	logic [wsfd_pkg::KeyIdxW-1:0]    kidx_inc;

	assign in_ch.ready = !out_vld_q || out_ch.ready;
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign b           = in_ch.rx_byte;
	assign len7        = b[wsfd_pkg::Len7W-1:0];
	assign kidx_inc    = kidx_q + 2'd1;

	always_comb begin
		case (kidx_q)
			2'd0:    kb = key_q[31:24];
			2'd1:    kb = key_q[23:16];
			2'd2:    kb = key_q[15:8];
			default: kb = key_q[7:0];
		endcase
		if (!masked_q) begin
			kb = '0;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		opcode_d  = opcode_q;
		masked_d  = masked_q;
		ext_cnt_d = ext_cnt_q;
		rem_d     = rem_q;
		key_d     = key_q;
		kidx_d    = kidx_q;
		closed_d  = closed_q;
		emit      = 1'b0;
		emit_data = 1'b0;
		emit_end  = 1'b0;
		emit_byte = '0;
		if (!closed_q) begin
			unique case (phase_q)
				wsfd_pkg::PH_HDR0: begin
					opcode_d  = b[wsfd_pkg::OpW-1:0];
					key_d     = '0;
					kidx_d    = '0;
					ext_cnt_d = '0;
					rem_d     = '0;
					phase_d   = wsfd_pkg::PH_HDR1;
				end
				wsfd_pkg::PH_HDR1: begin
					masked_d = b[7];
					if (len7 == wsfd_pkg::Len16Code || len7 == wsfd_pkg::Len64Code) begin
						ext_cnt_d = (len7 == wsfd_pkg::Len16Code) ? wsfd_pkg::Ext16Bytes
							: wsfd_pkg::Ext64Bytes;
						rem_d     = '0;
						phase_d   = wsfd_pkg::PH_EXT;
					end else begin
						rem_d  = {{(wsfd_pkg::LenW-wsfd_pkg::Len7W){1'b0}}, len7};
						kidx_d = '0;
						if (b[7]) begin
							phase_d = wsfd_pkg::PH_KEY;
						end else if (len7 == '0) begin
							emit     = 1'b1;
							emit_end = 1'b1;
						end else begin
							phase_d = wsfd_pkg::PH_DATA;
						end
					end
				end
				wsfd_pkg::PH_EXT: begin
					rem_d     = {rem_q[wsfd_pkg::LenW-9:0], b};
					ext_cnt_d = ext_cnt_q - 4'd1;
					if (ext_cnt_q == 4'd1) begin
						kidx_d = '0;
						if (masked_q) begin
							phase_d = wsfd_pkg::PH_KEY;
						end else if (rem_d == '0) begin
							emit     = 1'b1;
							emit_end = 1'b1;
						end else begin
							phase_d = wsfd_pkg::PH_DATA;
						end
					end
				end
				wsfd_pkg::PH_KEY: begin
					key_d  = {key_q[wsfd_pkg::KeyW-9:0], b};
					kidx_d = kidx_inc;
					if (kidx_inc == '0) begin
						if (rem_q == '0) begin
							emit     = 1'b1;
							emit_end = 1'b1;
						end else begin
							phase_d = wsfd_pkg::PH_DATA;
						end
					end
				end
				wsfd_pkg::PH_DATA: begin
					kidx_d    = kidx_inc;
					rem_d     = rem_q - 64'd1;
					emit      = 1'b1;
					emit_data = 1'b1;
					emit_byte = b ^ kb;
					emit_end  = (rem_q == 64'd1);
				end
				default: begin
					phase_d = wsfd_pkg::PH_HDR0;
				end
			endcase
			if (emit_end) begin
				phase_d = wsfd_pkg::PH_HDR0;
				if (opcode_q == wsfd_pkg::OP_CLOSE) begin
					closed_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= wsfd_pkg::PH_HDR0;
			opcode_q  <= '0;
			masked_q  <= 1'b0;
			ext_cnt_q <= '0;
			rem_q     <= '0;
			key_q     <= '0;
			kidx_q    <= '0;
			closed_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_acc) begin
				phase_q   <= phase_d;
				opcode_q  <= opcode_d;
				masked_q  <= masked_d;
				ext_cnt_q <= ext_cnt_d;
				rem_q     <= rem_d;
				key_q     <= key_d;
				kidx_q    <= kidx_d;
				closed_q  <= closed_d;
				out_vld_q <= emit;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			out_act_q  <= wsfd_pkg::action_of(opcode_q);
			out_op_q   <= opcode_q;
			out_data_q <= emit_data;
			out_byte_q <= emit_byte;
			out_end_q  <= emit_end;
		end
	end

	assign out_ch.valid        = out_vld_q;
	assign out_ch.action       = out_act_q;
	assign out_ch.frame_opcode = out_op_q;
	assign out_ch.has_data     = out_data_q;
	assign out_ch.payload_byte = out_byte_q;
	assign out_ch.frame_end    = out_end_q;

	// closed connection never reopens
	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |=> closed_q)
		else $error("closed flag cleared");

	// dropped bytes produce no result
	a_closed_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && closed_q) |=> !out_vld_q)
		else $error("result after close");

	// dataless results only end a frame and carry a zero byte
	a_dataless: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_data_q) |-> (out_end_q && out_byte_q == '0))
		else $error("bad dataless result");

	// payload phase always has bytes left
	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == wsfd_pkg::PH_DATA) |-> (rem_q != '0))
		else $error("payload phase with zero length");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer testbench
// Feeds a byte stream of WebSocket frames into the deframer and checks every
// result against an in-bench parser or a typed table row. A short table
// covers the header forms first, then random frames follow under three idle
// patterns. The run ends on a close frame with trailing bytes to be dropped.
// ----------------------------------------------------------------------------
module testbench;
	import wsfd_pkg::*;

	typedef struct packed {
		action_t            act;
		logic [OpW-1:0]     op;
		logic               has_data;
		logic [ByteW-1:0]   data;
		logic               frame_end;
	} result_t;

	typedef struct {
		logic [ByteW-1:0]   b;
		bit                 typed;
		result_t            want;
	} stim_row_t;

	localparam result_t NoRes = '0;
	localparam int NumDirected = 28;
	localparam int NumRandom = 1100;

	stim_row_t directed_tbl [NumDirected] = '{
		'{8'h81, 1'b0, NoRes},
		'{8'h00, 1'b1, '{ACT_DELIVER, OP_TEXT, 1'b0, 8'h00, 1'b1}},
		'{8'h89, 1'b0, NoRes},
		'{8'h81, 1'b0, NoRes},
		'{8'hFF, 1'b0, NoRes},
		'{8'h00, 1'b0, NoRes},
		'{8'h5A, 1'b0, NoRes},
		'{8'hA5, 1'b0, NoRes},
		'{8'h3C, 1'b1, '{ACT_ECHO, OP_PING, 1'b1, 8'hC3, 1'b1}},
		'{8'h02, 1'b0, NoRes},
		'{8'h7E, 1'b0, NoRes},
		'{8'h00, 1'b0, NoRes},
		'{8'h02, 1'b0, NoRes},
		'{8'h00, 1'b0, NoRes},
		'{8'hFF, 1'b0, NoRes},
		'{8'h8A, 1'b0, NoRes},
		'{8'h00, 1'b1, '{ACT_PONG, OP_PONG, 1'b0, 8'h00, 1'b1}},
		'{8'hF0, 1'b0, NoRes},
		'{8'h7F, 1'b0, NoRes},
		'{8'h00, 1'b0, NoRes},
		'{8'h00, 1'b0, NoRes},
		'{8'h00, 1'b0, NoRes},
		'{8'h00, 1'b0, NoRes},
		'{8'h00, 1'b0, NoRes},
		'{8'h00, 1'b0, NoRes},
		'{8'h00, 1'b0, NoRes},
		'{8'h01, 1'b0, NoRes},
		'{8'h55, 1'b1, '{ACT_IGNORE, OP_CONT, 1'b1, 8'h55, 1'b1}}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	wsfd_in_if  in_ch ();
	wsfd_out_if out_ch ();

	websocket_frame_deframer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #5 clk = ~clk;

	// parser state
	phase_t             hdr_phase;
	logic [OpW-1:0]     cur_op;
	logic               cur_masked;
	logic [ExtCntW-1:0] ext_left;
	logic [LenW-1:0]    len_left;
	logic [KeyW-1:0]    cur_key;
	logic [KeyIdxW-1:0] key_pos;
	logic               conn_closed;

	stim_row_t stim_q [$];
	result_t   expected_q [$];

	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int n_errors = 0;
	int n_accepted = 0;
	int n_results = 0;
	int n_frame_ends = 0;
	int n_frames = 0;

	task automatic emit_result(input logic with_data, input logic [ByteW-1:0] b,
		input logic last, output bit got, output result_t r);
		case (cur_op)
			OP_TEXT, OP_BINARY: r.act = ACT_DELIVER;
			OP_PING:            r.act = ACT_ECHO;
			OP_CLOSE:           r.act = ACT_CLOSE;
			OP_PONG:            r.act = ACT_PONG;
			default:            r.act = ACT_IGNORE;
		endcase
		r.op = cur_op;
		r.has_data = with_data;
		r.data = with_data ? b : 8'h00;
		r.frame_end = last;
		got = 1'b1;
		if (last) begin
			if (cur_op == OP_CLOSE)
				conn_closed = 1'b1;
			hdr_phase = PH_HDR0;
		end
	endtask

	task automatic finish_header(output bit got, output result_t r);
		key_pos = '0;
		if (len_left == '0)
			emit_result(1'b0, 8'h00, 1'b1, got, r);
		else
			hdr_phase = PH_DATA;
	endtask

	task automatic deframe_byte(input logic [ByteW-1:0] b, output bit got, output result_t r);
		logic [ByteW-1:0] kb;
		got = 1'b0;
		r = NoRes;
		if (conn_closed)
			return;
		case (hdr_phase)
			PH_HDR0: begin
				cur_op = b[3:0];
				cur_key = '0;
				key_pos = '0;
				ext_left = '0;
				len_left = '0;
				hdr_phase = PH_HDR1;
			end
			PH_HDR1: begin
				cur_masked = b[7];
				if (b[6:0] == Len16Code || b[6:0] == Len64Code) begin
					ext_left = (b[6:0] == Len16Code) ? Ext16Bytes : Ext64Bytes;
					len_left = '0;
					hdr_phase = PH_EXT;
				end else begin
					len_left = LenW'(b[6:0]);
					if (cur_masked) begin
						key_pos = '0;
						hdr_phase = PH_KEY;
					end else
						finish_header(got, r);
				end
			end
			PH_EXT: begin
				len_left = {len_left[LenW-9:0], b};
				ext_left = ext_left - 1'b1;
				if (ext_left == '0) begin
					if (cur_masked) begin
						key_pos = '0;
						hdr_phase = PH_KEY;
					end else
						finish_header(got, r);
				end
			end
			PH_KEY: begin
				cur_key = {cur_key[KeyW-9:0], b};
				key_pos = key_pos + 1'b1;
				if (key_pos == '0)
					finish_header(got, r);
			end
			PH_DATA: begin
				kb = cur_masked ? 8'(cur_key >> (24 - 8 * int'(key_pos))) : 8'h00;
				key_pos = key_pos + 1'b1;
				len_left = len_left - 1'b1;
				emit_result(1'b1, b ^ kb, len_left == '0, got, r);
			end
			default: hdr_phase = PH_HDR0;
		endcase
	endtask

	task automatic push_byte(input logic [ByteW-1:0] b);
		stim_q.insert(stim_q.size(), '{b, 1'b0, NoRes});
	endtask

	task automatic add_frame(input logic [OpW-1:0] op, input logic masked, input int len);
		int sel;
		logic [LenW-1:0] len64;
		n_frames++;
		push_byte({4'($urandom_range(15)), op});
		len64 = LenW'(len);
		sel = $urandom_range(99);
		if (len > 65535 || (len >= 126 && sel < 50) || sel < 15) begin
			push_byte({masked, Len64Code});
			for (int i = 7; i >= 0; i--)
				push_byte(len64[8*i +: 8]);
		end else if (len >= 126 || sel < 40) begin
			push_byte({masked, Len16Code});
			push_byte(len64[15:8]);
			push_byte(len64[7:0]);
		end else
			push_byte({masked, 7'(len)});
		if (masked)
			repeat (4) push_byte(8'($urandom_range(255)));
		repeat (len) push_byte(8'($urandom_range(255)));
	endtask

	task automatic add_random_frame();
		logic [OpW-1:0] op;
		int r;
		int len;
		r = $urandom_range(99);
		case ($urandom_range(5))
			0: op = OP_TEXT;
			1: op = OP_BINARY;
			2: op = OP_PING;
			3: op = OP_PONG;
			4: op = OP_CONT;
			default: begin
				op = 4'($urandom_range(15));
				while (op == OP_CLOSE)
					op = 4'($urandom_range(15));
			end
		endcase
		if (r < 12)
			len = 0;
		else if (r < 80)
			len = $urandom_range(1, 12);
		else if (r < 96)
			len = $urandom_range(13, 60);
		else if (r < 98)
			len = $urandom_range(100, 140);
		else
			len = $urandom_range(250, 300);
		add_frame(op, 1'($urandom_range(1)), len);
	endtask

	task automatic note_mismatch(input string what, input result_t w, input bit have_exp);
		n_errors++;
		if (n_errors <= 10) begin
			if (have_exp)
				$display("%s: exp act=%0d op=%h data=%b byte=%h end=%b", what,
					w.act, w.op, w.has_data, w.data, w.frame_end);
			else
				$display("%s: nothing expected", what);
			$display("    got act=%0d op=%h data=%b byte=%h end=%b", out_ch.action,
				out_ch.frame_opcode, out_ch.has_data, out_ch.payload_byte, out_ch.frame_end);
		end
	endtask

	// result checker and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		result_t w;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				n_results++;
				if (out_ch.frame_end === 1'b1)
					n_frame_ends++;
				if (expected_q.size() == 0) begin
					note_mismatch("unexpected transfer", NoRes, 1'b0);
				end else begin
					w = expected_q.pop_front();
					if (out_ch.action !== w.act || out_ch.frame_opcode !== w.op ||
						out_ch.has_data !== w.has_data || out_ch.payload_byte !== w.data ||
						out_ch.frame_end !== w.frame_end)
						note_mismatch("mismatch", w, 1'b1);
				end
			end
			out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	initial begin
		#5000000;
		$display("websocket_frame_deframer regression: fail");
		$finish;
	end

	initial begin
		bit got;
		result_t r;
		int n;
		in_ch.valid = 1'b0;
		in_ch.rx_byte = '0;
		hdr_phase = PH_HDR0;
		cur_op = '0;
		cur_masked = 1'b0;
		ext_left = '0;
		len_left = '0;
		cur_key = '0;
		key_pos = '0;
		conn_closed = 1'b0;

		foreach (directed_tbl[i])
			stim_q.insert(stim_q.size(), directed_tbl[i]);
		while (stim_q.size() < NumDirected + NumRandom)
			add_random_frame();
		// close frame, then bytes that must be dropped
		add_frame(OP_CLOSE, 1'b1, 3);
		repeat (8) push_byte(8'($urandom_range(255)));
		n = stim_q.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < n; i++) begin
			if (i == NumDirected) begin
				in_ch.valid <= 1'b0;
				do @(posedge clk); while (expected_q.size() != 0);
			end
			if (i < n / 3) begin
				src_idle_pct = 37;
				sink_idle_pct = 88;
			end else if (i < 2 * n / 3) begin
				src_idle_pct = 88;
				sink_idle_pct = 37;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			while ($urandom_range(99) < src_idle_pct) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
			end
			in_ch.valid <= 1'b1;
			in_ch.rx_byte <= stim_q[i].b;
			@(posedge clk);
			while (!in_ch.ready)
				@(posedge clk);
			n_accepted++;
			deframe_byte(stim_q[i].b, got, r);
			if (stim_q[i].typed)
				expected_q.insert(expected_q.size(), stim_q[i].want);
			else if (got)
				expected_q.insert(expected_q.size(), r);
		end
		in_ch.valid <= 1'b0;

		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		n_errors += expected_q.size();

		$display("%0d bytes in %0d frames fed, %0d results checked, %0d frame ends",
			n_accepted, n_frames, n_results, n_frame_ends);
		$display("all opcodes, 7/16/64-bit lengths, masked and unmasked, close with drop");
		if (n_errors == 0)
			$display("websocket_frame_deframer regression: pass");
		else
			$display("websocket_frame_deframer regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/wsfd_pkg.sv
hw/rtl/wsfd_if.sv
hw/rtl/websocket_frame_deframer.sv
tb/testbench.sv
